[hdl/bbox_pkg.sv]
// Shared types and constants of the point-list bounding box unit.
package bbox_pkg;
	localparam int AXES      = 3;
	localparam int CW        = 32;
	localparam int FRAC_W    = 16;
	localparam int DVD_W     = CW + FRAC_W;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		REG_DIMENSION = 2'd0,
		REG_RATIONAL  = 2'd1,
		REG_GROW      = 2'd2
	} reg_idx_t;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
		coord_t weight;
		logic   first_of_list;
		logic   last_of_list;
	} point_t;

	typedef struct packed {
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		logic   box_valid;
		logic   all_points_ok;
	} box_t;

	typedef struct packed {
		logic load;
		logic upd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic rational;
		logic div_done;
		logic last;
	} sts_t;
endpackage

[hdl/bbox_if.sv]
// Stream interfaces for points in and boxes out.
interface bbox_pt_if;
	logic                   valid;
	logic                   ready;
	logic signed [31:0]     coord_x;
	logic signed [31:0]     coord_y;
	logic signed [31:0]     coord_z;
	logic signed [31:0]     weight;
	logic                   first_of_list;
	logic                   last_of_list;
	modport source (output valid, coord_x, coord_y, coord_z, weight, first_of_list,
		last_of_list, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, weight, first_of_list,
		last_of_list, output ready);
endinterface

interface bbox_box_if;
	logic                   valid;
	logic                   ready;
	logic signed [31:0]     box_min_x;
	logic signed [31:0]     box_min_y;
	logic signed [31:0]     box_min_z;
	logic signed [31:0]     box_max_x;
	logic signed [31:0]     box_max_y;
	logic signed [31:0]     box_max_z;
	logic                   box_valid;
	logic                   all_points_ok;
	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, box_valid, all_points_ok, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, box_valid, all_points_ok, output ready);
endinterface

[hdl/bbox_div.sv]
// Bit-serial signed Q16.16 divider with saturation to 32 bits.
module bbox_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  bbox_pkg::coord_t num,
	input  bbox_pkg::coord_t den,
	output logic            done,
	output bbox_pkg::coord_t quot
);
	import bbox_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [CW:0]      rem_q;
	logic [CW-1:0]    den_q;
	logic             neg_q;
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    num_mag;
	logic [CW:0]      rem_sh;
	logic             ge;

	assign num_mag = num[CW-1] ? CW'(-num) : CW'(num);
	assign rem_sh  = {rem_q[CW-1:0], dvd_q[DVD_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign done    = busy_q && (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den[CW-1] ? CW'(-den) : CW'(den);
			neg_q <= num[CW-1] ^ den[CW-1];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	// Quotient magnitude sits in dvd_q once all steps are done.
	always_comb begin
		if (!neg_q) begin
			if (dvd_q > DVD_W'({1'b0, {(CW-1){1'b1}}})) begin
				quot = {1'b0, {(CW-1){1'b1}}};
			end else begin
				quot = coord_t'(dvd_q[CW-1:0]);
			end
		end else begin
			if (dvd_q > DVD_W'({1'b1, {(CW-1){1'b0}}})) begin
				quot = {1'b1, {(CW-1){1'b0}}};
			end else begin
				quot = coord_t'(-dvd_q[CW-1:0]);
			end
		end
	end
endmodule

[hdl/bbox_ctrl.sv]
// Controller state machine of the bounding box unit.
module bbox_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pt_valid,
	output logic          pt_ready,
	output logic          box_out_valid,
	input  logic          box_out_ready,
	input  bbox_pkg::sts_t sts,
	output bbox_pkg::cmd_t cmd
);
	import bbox_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_UPD  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign pt_ready      = (state_q == S_IDLE);
	assign box_out_valid = out_valid_q;
	assign out_free      = !out_valid_q || box_out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (pt_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.rational ? S_DIV : S_UPD;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (box_out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

[hdl/bbox_dp.sv]
// Datapath: configuration, point latch, dividers, list box and kept box.
module bbox_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [1:0]      cfg_data,
	input  bbox_pkg::point_t pt,
	input  bbox_pkg::cmd_t  cmd,
	output bbox_pkg::sts_t  sts,
	output bbox_pkg::box_t  box
);
	import bbox_pkg::*;

	logic [1:0] dim_q;
	logic       rational_q;
	logic       grow_q;

	coord_t     p_q [AXES];
	coord_t     w_q;
	logic       first_q;
	logic       last_q;

	coord_t     list_min_q [AXES];
	coord_t     list_max_q [AXES];
	logic       has_q;
	logic       ok_q;
	coord_t     kept_min_q [AXES];
	coord_t     kept_max_q [AXES];
	logic       kept_valid_q;
	box_t       box_q;

	coord_t     p_in   [AXES];
	coord_t     quot   [AXES];
	logic       done   [AXES];
	coord_t     p_eff  [AXES];
	coord_t     n_min  [AXES];
	coord_t     n_max  [AXES];
	logic [1:0] dim_eff;
	logic       take;
	logic       has_eff;
	logic       ok_eff;
	logic       keep_v;
	logic       new_valid;

	assign dim_eff = (dim_q == 2'd0) ? 2'd1 : dim_q;
	assign p_in[0] = pt.coord_x;
	assign p_in[1] = (dim_eff > 2'd1) ? pt.coord_y : '0;
	assign p_in[2] = (dim_eff > 2'd2) ? pt.coord_z : '0;

	for (genvar a = 0; a < AXES; a++) begin : g_div
		bbox_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cmd.load && rational_q),
			.num    (p_in[a]),
			.den    (pt.weight),
			.done   (done[a]),
			.quot   (quot[a])
		);
	end

	assign sts.rational = rational_q;
	assign sts.div_done = done[0] && done[1] && done[2];
	assign sts.last     = last_q;
	assign box          = box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q      <= 2'd3;
			rational_q <= 1'b0;
			grow_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMENSION: dim_q      <= cfg_data;
				REG_RATIONAL:  rational_q <= cfg_data[0];
				REG_GROW:      grow_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < AXES; a++) begin
				p_q[a] <= p_in[a];
			end
			w_q     <= pt.weight;
			first_q <= pt.first_of_list;
			last_q  <= pt.last_of_list;
		end
	end

	always_comb begin
		has_eff = first_q ? 1'b0 : has_q;
		ok_eff  = first_q ? 1'b1 : ok_q;
		take    = !(rational_q && (w_q == '0));
		if (!take) begin
			ok_eff = 1'b0;
		end
		for (int a = 0; a < AXES; a++) begin
			p_eff[a] = rational_q ? quot[a] : p_q[a];
		end
	end

	// Merge of the list box into the kept box at the end of a list.
	always_comb begin
		keep_v    = grow_q && kept_valid_q;
		new_valid = keep_v || has_q;
		for (int a = 0; a < AXES; a++) begin
			n_min[a] = kept_min_q[a];
			n_max[a] = kept_max_q[a];
			if (has_q) begin
				if (!keep_v || list_min_q[a] < kept_min_q[a]) begin
					n_min[a] = list_min_q[a];
				end
				if (!keep_v || list_max_q[a] > kept_max_q[a]) begin
					n_max[a] = list_max_q[a];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_q        <= 1'b0;
			ok_q         <= 1'b1;
			kept_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			has_q <= has_eff || take;
			ok_q  <= ok_eff;
		end else if (cmd.emit) begin
			has_q        <= 1'b0;
			ok_q         <= 1'b1;
			kept_valid_q <= new_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && take) begin
			for (int a = 0; a < AXES; a++) begin
				if (!has_eff) begin
					list_min_q[a] <= p_eff[a];
					list_max_q[a] <= p_eff[a];
				end else if (p_eff[a] < list_min_q[a]) begin
					list_min_q[a] <= p_eff[a];
				end else if (p_eff[a] > list_max_q[a]) begin
					list_max_q[a] <= p_eff[a];
				end
			end
		end
		if (cmd.emit) begin
			for (int a = 0; a < AXES; a++) begin
				kept_min_q[a] <= n_min[a];
				kept_max_q[a] <= n_max[a];
			end
			box_q.box_min_x     <= new_valid ? n_min[0] : '0;
			box_q.box_min_y     <= new_valid ? n_min[1] : '0;
			box_q.box_min_z     <= new_valid ? n_min[2] : '0;
			box_q.box_max_x     <= new_valid ? n_max[0] : '0;
			box_q.box_max_y     <= new_valid ? n_max[1] : '0;
			box_q.box_max_z     <= new_valid ? n_max[2] : '0;
			box_q.box_valid     <= new_valid;
			box_q.all_points_ok <= ok_q;
		end
	end
endmodule

[hdl/point_list_bounding_box_unit.sv]
// Top level of the point-list bounding box unit.
// The unit takes a stream of 3D points in signed Q16.16 and builds the axis-aligned
// bounding box of each list of points, marked by first_of_list and last_of_list. One
// point is worked on at a time. A point is accepted and updates the box; in rational
// mode a divide step comes between, dividing the three coordinates by the weight in
// bit-serial dividers that retire one quotient bit per cycle over a 48-bit dividend.
// A point ending a list adds an emit step in which the list box is merged into the
// kept box and loaded into the output register; the step waits until an earlier
// result is taken. The next point is accepted while a result still sits in the
// output register. Each box transaction carries the kept box (all zero when
// invalid), its validity and the all-points-ok flag. Configuration must be written
// through cfg_we, cfg_index and cfg_data only while the unit is idle; the unit does
// not check it. Index 0 is the dimension, 1 rational mode, 2 grow mode.
module point_list_bounding_box_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	bbox_pt_if.sink     points,
	bbox_box_if.source  boxes
);
	import bbox_pkg::*;

	cmd_t   cmd;
	sts_t   sts;
	point_t pt;
	box_t   box;

	// Pack the incoming transaction for the datapath.
	assign pt.coord_x       = points.coord_x;
	assign pt.coord_y       = points.coord_y;
	assign pt.coord_z       = points.coord_z;
	assign pt.weight        = points.weight;
	assign pt.first_of_list = points.first_of_list;
	assign pt.last_of_list  = points.last_of_list;

	bbox_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.pt_valid      (points.valid),
		.pt_ready      (points.ready),
		.box_out_valid (boxes.valid),
		.box_out_ready (boxes.ready),
		.sts           (sts),
		.cmd           (cmd)
	);

	bbox_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pt        (pt),
		.cmd       (cmd),
		.sts       (sts),
		.box       (box)
	);

	// The output register lives in the datapath; unpack it onto the box stream.
	assign boxes.box_min_x     = box.box_min_x;
	assign boxes.box_min_y     = box.box_min_y;
	assign boxes.box_min_z     = box.box_min_z;
	assign boxes.box_max_x     = box.box_max_x;
	assign boxes.box_max_y     = box.box_max_y;
	assign boxes.box_max_z     = box.box_max_z;
	assign boxes.box_valid     = box.box_valid;
	assign boxes.all_points_ok = box.all_points_ok;
endmodule

[sim/tb_point_list_bounding_box_unit.sv]
`timescale 1ns / 1ps
// Testbench of the point-list bounding box unit, checked against a box predictor.
module tb_point_list_bounding_box_unit;
	import bbox_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_DIMENSION;
	logic [1:0] cfg_data = 2'd0;

	bbox_pt_if  pt_ch ();
	bbox_box_if box_ch ();

	point_list_bounding_box_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .points(pt_ch.sink), .boxes(box_ch.source)
	);

	always #10 clk = ~clk;

	// Predictor state: the configuration and the list and kept boxes.
	logic [1:0]  dim_reg = 2'd3;
	logic        rational_reg = 1'b0;
	logic        grow_reg = 1'b0;
	coord_t      lst_min [AXES];
	coord_t      lst_max [AXES];
	logic        lst_has = 1'b0;
	logic        lst_ok = 1'b1;
	coord_t      kpt_min [AXES];
	coord_t      kpt_max [AXES];
	logic        kpt_valid = 1'b0;

	point_t pending_points [$];
	box_t   expected_boxes [$];

	int  mismatches = 0;
	int  boxes_seen = 0;
	int  points_sent = 0;
	longint cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	logic receiver_hold = 1'b0;
	event hold_go;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on box %0d, %s: got %h, expected %h", boxes_seen, what, got, want);
		mismatches++;
	endtask

	// Q16.16 quotient, truncated toward zero and saturated to 32 bits.
	function automatic coord_t q16_quotient(input coord_t num, input coord_t den);
		longint n;
		longint q;
		n = longint'(num) * 65536;
		q = n / longint'(den);
		if (q > 64'sd2147483647) return 32'sh7fffffff;
		if (q < -64'sd2147483648) return 32'sh80000000;
		return coord_t'(q);
	endfunction

	// Advances the predictor by one accepted point and queues the box it causes.
	task automatic predict_box(input point_t p);
		coord_t c [AXES];
		int     used;
		logic   take;
		box_t   b;
		used = (dim_reg == 2'd0) ? 1 : int'(dim_reg);
		take = 1'b1;
		if (p.first_of_list) begin
			lst_has = 1'b0;
			lst_ok = 1'b1;
		end
		c[0] = p.coord_x;
		c[1] = (used > 1) ? p.coord_y : '0;
		c[2] = (used > 2) ? p.coord_z : '0;
		if (rational_reg) begin
			if (p.weight == 0) begin
				take = 1'b0;
				lst_ok = 1'b0;
			end else begin
				for (int a = 0; a < used; a++) c[a] = q16_quotient(c[a], p.weight);
			end
		end
		if (take) begin
			if (!lst_has) begin
				for (int a = 0; a < AXES; a++) begin
					lst_min[a] = c[a];
					lst_max[a] = c[a];
				end
				lst_has = 1'b1;
			end else begin
				for (int a = 0; a < AXES; a++) begin
					if (c[a] < lst_min[a]) lst_min[a] = c[a];
					else if (c[a] > lst_max[a]) lst_max[a] = c[a];
				end
			end
		end
		if (!p.last_of_list) return;
		if (!(grow_reg && kpt_valid)) kpt_valid = 1'b0;
		if (lst_has) begin
			for (int a = 0; a < AXES; a++) begin
				if (!kpt_valid || lst_min[a] < kpt_min[a]) kpt_min[a] = lst_min[a];
				if (!kpt_valid || lst_max[a] > kpt_max[a]) kpt_max[a] = lst_max[a];
			end
			kpt_valid = 1'b1;
		end
		b.box_min_x = kpt_valid ? kpt_min[0] : '0;
		b.box_min_y = kpt_valid ? kpt_min[1] : '0;
		b.box_min_z = kpt_valid ? kpt_min[2] : '0;
		b.box_max_x = kpt_valid ? kpt_max[0] : '0;
		b.box_max_y = kpt_valid ? kpt_max[1] : '0;
		b.box_max_z = kpt_valid ? kpt_max[2] : '0;
		b.box_valid = kpt_valid;
		b.all_points_ok = lst_ok;
		expected_boxes.push_back(b);
		lst_has = 1'b0;
		lst_ok = 1'b1;
	endtask

	// Point driver. It runs the predictor on each accepted transaction, so the
	// expectation exists before the box can come out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_ch.valid <= 1'b0;
			pt_ch.coord_x <= '0;
			pt_ch.coord_y <= '0;
			pt_ch.coord_z <= '0;
			pt_ch.weight <= '0;
			pt_ch.first_of_list <= 1'b0;
			pt_ch.last_of_list <= 1'b0;
		end else begin
			automatic logic offer = pt_ch.valid;
			if (pt_ch.valid && pt_ch.ready) begin
				predict_box(pending_points.pop_front());
				points_sent++;
				offer = 1'b0;
			end
			if (!offer && pending_points.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				pt_ch.coord_x <= pending_points[0].coord_x;
				pt_ch.coord_y <= pending_points[0].coord_y;
				pt_ch.coord_z <= pending_points[0].coord_z;
				pt_ch.weight <= pending_points[0].weight;
				pt_ch.first_of_list <= pending_points[0].first_of_list;
				pt_ch.last_of_list <= pending_points[0].last_of_list;
				offer = 1'b1;
			end
			pt_ch.valid <= offer;
		end
	end

	// Long receiver hold-off, counted in cycles on its own.
	always begin
		@(hold_go);
		receiver_hold <= 1'b1;
		repeat (300) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// Box monitor: compares each accepted box with the oldest expectation, then
	// decides readiness for the next cycle. A hold-off keeps ready low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_ch.ready <= 1'b0;
		end else begin
			if (box_ch.valid && box_ch.ready) begin
				if (expected_boxes.size() == 0) begin
					report_mismatch("unexpected box", 32'(box_ch.box_valid), 32'd0);
				end else begin
					automatic box_t w = expected_boxes.pop_front();
					if (box_ch.box_min_x !== w.box_min_x)
						report_mismatch("box_min_x", box_ch.box_min_x, w.box_min_x);
					if (box_ch.box_min_y !== w.box_min_y)
						report_mismatch("box_min_y", box_ch.box_min_y, w.box_min_y);
					if (box_ch.box_min_z !== w.box_min_z)
						report_mismatch("box_min_z", box_ch.box_min_z, w.box_min_z);
					if (box_ch.box_max_x !== w.box_max_x)
						report_mismatch("box_max_x", box_ch.box_max_x, w.box_max_x);
					if (box_ch.box_max_y !== w.box_max_y)
						report_mismatch("box_max_y", box_ch.box_max_y, w.box_max_y);
					if (box_ch.box_max_z !== w.box_max_z)
						report_mismatch("box_max_z", box_ch.box_max_z, w.box_max_z);
					if (box_ch.box_valid !== w.box_valid)
						report_mismatch("box_valid", 32'(box_ch.box_valid),
							32'(w.box_valid));
					if (box_ch.all_points_ok !== w.all_points_ok)
						report_mismatch("all_points_ok", 32'(box_ch.all_points_ok),
							32'(w.all_points_ok));
				end
				boxes_seen++;
			end
			if (receiver_hold) begin
				box_ch.ready <= 1'b0;
			end else begin
				box_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on the whole run. Rational points are the slowest and idling stretches
	// the run further, but the limit lies far above its length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Random coordinate: mostly moderate, sometimes extreme or fully random bits.
	function automatic coord_t pick_coord();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	// Random weight: zero now and then, small weights that push quotients to
	// saturation, and negative and random ones.
	function automatic coord_t pick_weight();
		case ($urandom_range(11))
			0: return '0;
			1: return 32'sd1;
			2: return -32'sd1;
			3: return 32'sh80000000;
			4, 5: return coord_t'($urandom);
			default: return coord_t'(int'($urandom_range(400000)) - 200000);
		endcase
	endfunction

	function automatic point_t make_point(input coord_t x, input coord_t y, input coord_t z,
			input coord_t w, input logic f, input logic l);
		point_t p;
		p.coord_x = x;
		p.coord_y = y;
		p.coord_z = z;
		p.weight = w;
		p.first_of_list = f;
		p.last_of_list = l;
		return p;
	endfunction

	// Queues a well-formed list of n points, with the odd missing first mark.
	task automatic queue_list(input int n);
		for (int i = 0; i < n; i++)
			pending_points.push_back(make_point(pick_coord(), pick_coord(), pick_coord(),
				pick_weight(), (i == 0) ? ($urandom_range(7) != 0) : 1'b0, i == n - 1));
	endtask

	// Waits until every queued point is taken and every box has arrived, then
	// lets the unit settle past a rational point's worth of cycles.
	task automatic drain();
		while (pending_points.size() > 0 || pt_ch.valid || expected_boxes.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Drives one register write; the caller drops the write enable afterwards.
	task automatic write_reg(input reg_idx_t idx, input logic [1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_DIMENSION: dim_reg = value;
			REG_RATIONAL:  rational_reg = value[0];
			default:       grow_reg = value[0];
		endcase
	endtask

	task automatic set_config(input logic [1:0] d, input logic r, input logic g);
		write_reg(REG_DIMENSION, d);
		write_reg(REG_RATIONAL, {1'b0, r});
		write_reg(REG_GROW, {1'b0, g});
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first without division: extremes of every field, a
		// one-point list, a list with no first mark, and a first mark that
		// restarts an open list.
		set_config(2'd3, 1'b0, 1'b0);
		pending_points.push_back(make_point(32'sh7fffffff, 32'sh80000000, 32'sh0, 0,
			1'b1, 1'b1));
		pending_points.push_back(make_point(32'sh80000000, 32'sh7fffffff, -1, -1,
			1'b0, 1'b0));
		pending_points.push_back(make_point(5, 6, 7, 0, 1'b0, 1'b1));
		pending_points.push_back(make_point(100, 100, 100, 0, 1'b1, 1'b0));
		pending_points.push_back(make_point(-3, 9, 2, 0, 1'b1, 1'b0));
		pending_points.push_back(make_point(4, -9, 8, 0, 1'b0, 1'b1));
		drain();

		// Rational mode with grow: zero weights, an empty list that keeps the
		// grown box, saturating quotients and negative weights.
		set_config(2'd2, 1'b1, 1'b1);
		pending_points.push_back(make_point(32'h10000, 32'h20000, 3, 32'h20000, 1'b1, 1'b1));
		pending_points.push_back(make_point(7, 7, 7, 0, 1'b1, 1'b1));
		pending_points.push_back(make_point(32'sh7fffffff, 32'sh80000000, 1, 1, 1'b1, 1'b0));
		pending_points.push_back(make_point(32'sh80000000, 32'h30000, 1, -1, 1'b0, 1'b0));
		pending_points.push_back(make_point(32'sh80000000, 5, 1, 32'sh80000000, 1'b0, 1'b1));
		pending_points.push_back(make_point(-32'sh50000, 32'h50000, 1, 32'sh7fffffff,
			1'b1, 1'b1));
		drain();

		// Dimension zero acts as one; grow off clears an empty list to invalid.
		set_config(2'd0, 1'b1, 1'b0);
		pending_points.push_back(make_point(32'h40000, 1, 2, 32'h20000, 1'b1, 1'b1));
		pending_points.push_back(make_point(1, 1, 1, 0, 1'b1, 1'b1));
		pending_points.push_back(make_point(9, 8, 7, 32'h10000, 1'b1, 1'b1));
		drain();
		set_config(2'd1, 1'b0, 1'b1);
		pending_points.push_back(make_point(-9, 8, 7, 0, 1'b1, 1'b1));
		pending_points.push_back(make_point(99, 8, 7, 0, 1'b1, 1'b1));
		drain();

		// Random phases: configuration, then idling mix per phase.
		for (int ph = 0; ph < 16; ph++) begin
			automatic logic r = (ph % 4 >= 2);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			set_config(2'($urandom_range(3)), r, 1'($urandom_range(1)));
			// Rational points are slow, so those phases carry fewer of them.
			while (pending_points.size() < (r ? 50 : 150)) begin
				if ($urandom_range(9) == 0)
					pending_points.push_back(make_point(pick_coord(), pick_coord(),
						pick_coord(), pick_weight(), 1'($urandom), 1'($urandom)));
				else
					queue_list($urandom_range(1, 6));
			end
			// Once per pass of the mix the receiver holds off for a long stretch
			// while points keep coming, so the unit backs up its input.
			if (ph % 4 == 0) -> hold_go;
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("Ran %0d points and checked %0d boxes over all dimensions,", points_sent,
			boxes_seen);
		$display("plain and rational mode, grow on and off, under mixed idling and stalls.");
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
